// ===== hdl/dsky_packet_display_decoder_unit_macros.svh =====
// Assertion macros for the display packet decoder.
`ifndef DSKY_PACKET_DISPLAY_DECODER_UNIT_MACROS_SVH
`define DSKY_PACKET_DISPLAY_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define DPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpd assertion failed");
// Next-cycle implication, checked out of reset.
`define DPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpd assertion failed");
`else
`define DPD_ASSERT_IMPL(label, ante, cons)
`define DPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/dpd_pkg.sv =====
// Types, constants and the segment code table for the display packet decoder.
package dpd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_DIGIT = 5;
  localparam int unsigned OUT_CNT_W = 16;

  // Frame position tags in the top two bits of each byte
  localparam logic [1:0] TAG_HEAD  = 2'b00;
  localparam logic [1:0] TAG_BYTE1 = 2'b01;
  localparam logic [1:0] TAG_BYTE2 = 2'b10;
  localparam logic [1:0] TAG_BYTE3 = 2'b11;

  // Channel carrying the display rows
  localparam logic [7:0] CHAN_DISPLAY = 8'd8;

  // Row codes
  localparam logic [3:0] ROW_NONE       = 4'd0;
  localparam logic [3:0] ROW_DIGITS_45  = 4'd6;
  localparam logic [3:0] ROW_DIGITS_23  = 4'd7;
  localparam logic [3:0] ROW_DIGIT_1    = 4'd8;
  localparam logic [3:0] ROW_LAST_KNOWN = 4'd11;

  localparam logic [3:0] DIGIT_BLANK = 4'd15;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // Decoded view of one complete frame
  typedef struct packed {
    logic   sig_ok;     // bytes 1..3 carry the right tags
    logic   chan_hit;   // channel is the display channel
    logic [3:0] row;
    digit_t left_dig;
    digit_t right_dig;
  } frame_info_t;

  // 5-bit segment code to digit
  function automatic digit_t seg_to_digit(input logic [4:0] code);
    digit_t d;
    unique case (code)
      5'd0:    d = 4'd0;
      5'd3:    d = 4'd1;
      5'd15:   d = 4'd4;
      5'd19:   d = 4'd7;
      5'd21:   d = 4'd0;
      5'd25:   d = 4'd2;
      5'd27:   d = 4'd3;
      5'd28:   d = 4'd6;
      5'd29:   d = 4'd8;
      5'd30:   d = 4'd5;
      5'd31:   d = 4'd9;
      default: d = DIGIT_BLANK;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/dpd_frame_decode.sv =====
// Field extraction and checks for one complete 4-byte frame.
module dpd_frame_decode (
  input  dpd_pkg::byte_t       byte0,
  input  dpd_pkg::byte_t       byte1,
  input  dpd_pkg::byte_t       byte2,
  input  dpd_pkg::byte_t       byte3,
  output dpd_pkg::frame_info_t info
);
  import dpd_pkg::*;

  logic [7:0] chan;
  logic [4:0] left_code;
  logic [4:0] right_code;

  // channel = byte0[4:0] : byte1[5:3]
  assign chan       = {byte0[4:0], byte1[5:3]};
  // value bits 9:5 and 4:0
  assign left_code  = {byte2[3:0], byte3[5]};
  assign right_code = byte3[4:0];

  always_comb begin
    info.sig_ok    = (byte1[7:6] == TAG_BYTE1) && (byte2[7:6] == TAG_BYTE2) &&
                     (byte3[7:6] == TAG_BYTE3);
    info.chan_hit  = (chan == CHAN_DISPLAY);
    // value bits 14:11
    info.row       = {byte1[2:0], byte2[5]};
    info.left_dig  = seg_to_digit(left_code);
    info.right_dig = seg_to_digit(right_code);
  end

endmodule

// ===== hdl/dsky_packet_display_decoder_unit.sv =====
// Top level of the display packet decoder: frame assembly, digit tracking, output register.
//
// Usage: link bytes enter on the in_ stream, one byte per transaction. A byte
// with top bits 00 opens a 4-byte frame; a good display-channel frame updates
// the five tracked digits of the first display register. A result transaction
// on the out_ stream carries the five digits and the saturated bad-row count,
// and is sent only when the digits differ from those in the last result.
// Frames with unknown rows only bump the bad-row count.
// Timing: the last frame byte passes the input register, then the result
// register, before out_tvalid rises for its result transaction.
// Throughput: one byte per cycle while no stalled result holds the input;
// all frame work sits between the input register and the result register.
// Reset: synchronous rst_n clears the open frame, the digits, the last sent
// digits and the count; both stages come up empty.
// Stall: when out_tready is low with a result waiting, the result holds and
// the input register still takes one byte if empty; after that in_tready
// drops until the result is taken.
`include "dsky_packet_display_decoder_unit_macros.svh"
module dsky_packet_display_decoder_unit #(
  parameter int unsigned ERROR_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [3:0] digit_one, [7:4] digit_two, [11:8] digit_three,
                                  // [15:12] digit_four, [19:16] digit_five,
                                  // [35:20] bad_row_count, [39:36] zero
);
  import dpd_pkg::*;

  localparam int unsigned EXT_W = (ERROR_COUNT_WIDTH > OUT_CNT_W) ?
                                  ERROR_COUNT_WIDTH : OUT_CNT_W;

  // Input register
  logic   s1_valid_r, s1_valid_nxt;
  byte_t  s1_byte_r,  s1_byte_nxt;
  logic   s1_adv;

  // Frame assembly
  byte_t      frame_r [3];
  byte_t      frame_nxt [3];
  logic [1:0] fill_r, fill_nxt;
  logic       frame_done;

  // Digit tracking
  digit_t shown_r [NUM_DIGIT];
  digit_t shown_nxt [NUM_DIGIT];
  digit_t sent_r [NUM_DIGIT];
  digit_t sent_nxt [NUM_DIGIT];
  logic [ERROR_COUNT_WIDTH-1:0] tally_r, tally_nxt;
  logic [EXT_W-1:0]             tally_ext;
  logic [OUT_CNT_W-1:0]         tally_sat;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r,  out_data_nxt;

  frame_info_t info;
  logic        row_known;
  logic        differ;
  logic        res_fire;

  dpd_frame_decode u_decode (
    .byte0 (frame_r[0]),
    .byte1 (frame_r[1]),
    .byte2 (frame_r[2]),
    .byte3 (s1_byte_r),
    .info  (info)
  );

  // Handshake: the input stage moves when the result register is free or drains
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_tdata;
    end
  end

  // Frame assembly on the byte leaving the input register
  always_comb begin
    frame_nxt  = frame_r;
    fill_nxt   = fill_r;
    frame_done = 1'b0;
    if (s1_adv) begin
      if (s1_byte_r[7:6] == TAG_HEAD) begin
        frame_nxt[0] = s1_byte_r;
        fill_nxt     = 2'd1;
      end else if (fill_r == 2'd3) begin
        fill_nxt   = 2'd0;
        frame_done = 1'b1;
      end else if (fill_r != 2'd0) begin
        frame_nxt[fill_r] = s1_byte_r;
        fill_nxt          = fill_r + 2'd1;
      end
    end
  end

  // Saturated count for the output field
  assign tally_ext = EXT_W'(tally_r);
  assign tally_sat = (tally_ext > EXT_W'({OUT_CNT_W{1'b1}})) ? {OUT_CNT_W{1'b1}}
                                                             : tally_ext[OUT_CNT_W-1:0];

  assign row_known = (info.row != ROW_NONE) && (info.row <= ROW_LAST_KNOWN);

  // Row update, change detect and bad-row count
  always_comb begin
    shown_nxt = shown_r;
    sent_nxt  = sent_r;
    tally_nxt = tally_r;
    differ    = 1'b0;
    res_fire  = 1'b0;
    if (frame_done && info.sig_ok && info.chan_hit) begin
      if (!row_known) begin
        if (tally_r != {ERROR_COUNT_WIDTH{1'b1}}) begin
          tally_nxt = tally_r + 1'b1;
        end
      end else begin
        if (info.row == ROW_DIGIT_1) begin
          shown_nxt[0] = info.right_dig;
        end else if (info.row == ROW_DIGITS_23) begin
          shown_nxt[1] = info.left_dig;
          shown_nxt[2] = info.right_dig;
        end else if (info.row == ROW_DIGITS_45) begin
          shown_nxt[3] = info.left_dig;
          shown_nxt[4] = info.right_dig;
        end
        for (int k = 0; k < NUM_DIGIT; k++) begin
          if (shown_nxt[k] != sent_r[k]) begin
            differ = 1'b1;
          end
        end
        if (differ) begin
          res_fire = 1'b1;
          sent_nxt = shown_nxt;
        end
      end
    end
  end

  // Result register: holds while stalled, else takes this cycle's result
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_valid_r || out_tready) begin
      out_valid_nxt = res_fire;
      out_data_nxt  = {4'd0, tally_sat, shown_nxt[4], shown_nxt[3], shown_nxt[2],
                       shown_nxt[1], shown_nxt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fill_r      <= 2'd0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        frame_r[k] <= '0;
      end
      for (int k = 0; k < NUM_DIGIT; k++) begin
        shown_r[k] <= '0;
        sent_r[k]  <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fill_r      <= fill_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
      frame_r     <= frame_nxt;
      shown_r     <= shown_nxt;
      sent_r      <= sent_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    s1_byte_r  <= s1_byte_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A waiting result always matches the last sent digits
  `DPD_ASSERT_IMPL(a_out_matches_sent, out_valid_r, out_data_r[19:0] == {sent_r[4], sent_r[3], sent_r[2], sent_r[1], sent_r[0]})
  // The bad-row count never goes down
  `DPD_ASSERT_IMPL(a_tally_monotonic, $past(rst_n), tally_r >= $past(tally_r))
  // With no result waiting, the input side is always open
  `DPD_ASSERT_IMPL(a_ready_when_empty, !out_valid_r, in_tready)
  // An unknown-row frame never produces a result
  `DPD_ASSERT_NEXT(a_bad_row_no_result, frame_done && info.sig_ok && info.chan_hit && !row_known && !(out_valid_r && !out_tready), !out_valid_r)

endmodule
